// ===== rtl/qssm_pkg.sv =====
// Shared types and constants of the quad-SPI serial SRAM master.
`default_nettype none

package qssm_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_QUAD_EN     = 3'd0,
      OP_RESET_SPI   = 3'd1,
      OP_WRITE_START = 3'd2,
      OP_READ_START  = 3'd3,
      OP_DATA        = 3'd4,
      OP_END         = 3'd5
   } op_type;

   // Kinds of pin sequences that the front hands to the back.
   typedef enum logic [2:0] {
      KIND_QUAD_EN   = 3'd0,
      KIND_RESET_SPI = 3'd1,
      KIND_START     = 3'd2,
      KIND_WR_DATA   = 3'd3,
      KIND_RD_DATA   = 3'd4,
      KIND_END       = 3'd5,
      KIND_ERROR     = 3'd6
   } kind_type;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SEQ  = 2'd1;
   localparam logic [1:0] STATUS_MODE = 2'd2;

   // Open transfer codes.
   localparam logic [1:0] OPEN_NONE  = 2'd0;
   localparam logic [1:0] OPEN_WRITE = 2'd1;
   localparam logic [1:0] OPEN_READ  = 2'd2;

   // Command values and fixed pin levels.
   localparam logic [7:0] QUAD_EN_CMD   = 8'h38;
   localparam logic [3:0] WRITE_CMD     = 4'h2;
   localparam logic [3:0] READ_CMD      = 4'h3;
   localparam logic [3:0] QUAD_IDLE     = 4'hF;
   localparam logic [3:0] SERIAL_IDLE   = 4'h1;
   localparam logic [3:0] DUMMY_RESET   = 4'd2;
   localparam logic [3:0] DUMMY_MAX     = 4'd8;
   localparam int         MAX_EVENTS    = 15;

   // Last beat index of the fixed-length sequences.
   localparam logic [3:0] QUAD_EN_LAST   = 4'd9;
   localparam logic [3:0] RESET_SPI_LAST = 4'd3;

   // Defaults of the top-level parameters.
   localparam int DEF_ADDR_BITS   = 16;
   localparam int DEF_QUEUE_DEPTH = 2;

   // One classified request as it waits between front and back.
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  cmd;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic [7:0]  read_byte;
      logic [3:0]  dummies;
      logic        cs_n;
      logic [1:0]  status;
   } desc_type;

   // Handshake between the descriptor queue and its users.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

`default_nettype wire

// ===== rtl/qssm_front.sv =====
// Front end: checks each request against the protocol state and classifies it.
`default_nettype none

module qssm_front #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [2:0]          req_op,
   input  wire logic [15:0]         req_address,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic [3:0]          req_pin_high_nibble,
   input  wire logic [3:0]          req_pin_low_nibble,
   input  wire logic                csr_write,
   input  wire logic [3:0]          csr_dummy_beats,
   input  wire qssm_pkg::queue_stat_type q_stat,
   output logic                     q_write,
   output qssm_pkg::desc_type       q_wr_data
);
   import qssm_pkg::*;

   localparam int         ADDR_NIBBLES = (ADDR_BITS + 3) / 4;
   localparam logic [3:0] DUMMY_CAP    = 4'(MAX_EVENTS - 3 - ADDR_NIBBLES);

   logic       quad_ff, quad_in;
   logic [1:0] open_ff, open_in;
   logic [3:0] dummy_ff;
   logic [3:0] dummy_sat;
   logic [3:0] dummy_cnt;
   logic       accept;

   assign accept  = push && !q_stat.full;
   assign q_write = accept;

   // Dummy beats saturate at eight and at what fits in one item.
   always_comb begin
      dummy_sat = (dummy_ff > DUMMY_MAX) ? DUMMY_MAX : dummy_ff;
      dummy_cnt = (dummy_sat > DUMMY_CAP) ? DUMMY_CAP : dummy_sat;
   end

   // Classify the request and work out the next protocol state.
   always_comb begin
      quad_in             = quad_ff;
      open_in             = open_ff;
      q_wr_data.kind      = KIND_ERROR;
      q_wr_data.cmd       = WRITE_CMD;
      q_wr_data.address   = req_address;
      q_wr_data.data_byte = req_data_byte;
      q_wr_data.read_byte = {req_pin_high_nibble, req_pin_low_nibble};
      q_wr_data.dummies   = '0;
      q_wr_data.cs_n      = (open_ff == OPEN_NONE);
      q_wr_data.status    = STATUS_SEQ;
      case (req_op)
         OP_QUAD_EN: begin
            if (open_ff == OPEN_NONE && !quad_ff) begin
               q_wr_data.kind   = KIND_QUAD_EN;
               q_wr_data.status = STATUS_OK;
               quad_in          = 1'b1;
            end
         end
         OP_RESET_SPI: begin
            if (open_ff == OPEN_NONE) begin
               q_wr_data.kind   = KIND_RESET_SPI;
               q_wr_data.status = STATUS_OK;
               quad_in          = 1'b0;
            end
         end
         OP_WRITE_START, OP_READ_START: begin
            if (open_ff != OPEN_NONE) begin
               q_wr_data.status = STATUS_SEQ;
            end else if (!quad_ff) begin
               q_wr_data.status = STATUS_MODE;
            end else begin
               q_wr_data.kind   = KIND_START;
               q_wr_data.status = STATUS_OK;
               if (req_op == OP_WRITE_START) begin
                  q_wr_data.cmd = WRITE_CMD;
                  open_in       = OPEN_WRITE;
               end else begin
                  q_wr_data.cmd     = READ_CMD;
                  q_wr_data.dummies = dummy_cnt;
                  open_in           = OPEN_READ;
               end
            end
         end
         OP_DATA: begin
            if (open_ff == OPEN_WRITE) begin
               q_wr_data.kind   = KIND_WR_DATA;
               q_wr_data.status = STATUS_OK;
            end else if (open_ff == OPEN_READ) begin
               q_wr_data.kind   = KIND_RD_DATA;
               q_wr_data.status = STATUS_OK;
            end
         end
         OP_END: begin
            if (open_ff != OPEN_NONE) begin
               q_wr_data.kind   = KIND_END;
               q_wr_data.status = STATUS_OK;
               open_in          = OPEN_NONE;
            end
         end
         default: begin
            q_wr_data.status = STATUS_SEQ;
         end
      endcase
   end

   // Protocol state and the dummy-beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff  <= 1'b0;
         open_ff  <= OPEN_NONE;
         dummy_ff <= DUMMY_RESET;
      end else begin
         if (accept) begin
            quad_ff <= quad_in;
            open_ff <= open_in;
         end
         if (csr_write) begin
            dummy_ff <= csr_dummy_beats;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/qssm_queue.sv =====
// Short descriptor queue between the front end and the pin sequencer.
`default_nettype none

module qssm_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire qssm_pkg::desc_type  wr_data,
   input  wire logic                rd_en,
   output qssm_pkg::desc_type       rd_data,
   output qssm_pkg::queue_stat_type stat
);
   import qssm_pkg::*;

   localparam int                 PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int                 CNT_W    = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(DEPTH);

   desc_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign rd_data    = entry_ff[rd_ptr_ff];

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !stat.full || rd_en)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !stat.empty)
      else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/qssm_back.sv =====
// Pin sequencer: expands each descriptor into pin events, one per cycle unless pop stalls.
`default_nettype none

module qssm_back #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire qssm_pkg::queue_stat_type q_stat,
   input  wire qssm_pkg::desc_type  q_rd_data,
   output logic                     q_read,
   input  wire logic                pop,
   output logic                     empty,
   output logic                     rsp_chip_select_n,
   output logic                     rsp_clock_pulse,
   output logic [3:0]               rsp_sio_value,
   output logic                     rsp_sio_drive,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_byte_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);
   import qssm_pkg::*;

   localparam int         ADDR_NIBBLES = (ADDR_BITS + 3) / 4;
   localparam int         ADDR_W       = ADDR_NIBBLES * 4;
   localparam logic [3:0] ADDR_FIRST   = 4'd3;
   localparam logic [3:0] ADDR_LAST    = 4'(2 + ADDR_NIBBLES);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_QUAD   = 8'b0000_0010,
      S_RESET  = 8'b0000_0100,
      S_START  = 8'b0000_1000,
      S_WDATA  = 8'b0001_0000,
      S_RDATA  = 8'b0010_0000,
      S_END    = 8'b0100_0000,
      S_ERROR  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        idx_ff, idx_in;
   logic [3:0]        last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [3:0]        cmd_ff;
   logic [7:0]        data_ff;
   logic [7:0]        rbyte_ff;
   logic              cs_ff;
   logic [1:0]        status_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_cs_ff, out_clk_ff, out_drv_ff, out_bv_ff, out_last_ff;
   logic [3:0]        out_val_ff;
   logic [7:0]        out_rb_ff;
   logic [1:0]        out_st_ff;

   logic              ev_cs, ev_clk, ev_drv, ev_bv;
   logic [3:0]        ev_val;
   logic [7:0]        ev_rb;
   logic [1:0]        ev_st;
   logic [2:0]        qe_bit;
   logic              can_emit, emit, is_last, load;
   state_type         load_state;
   logic [3:0]        load_last;

   assign can_emit = !out_valid_ff || pop;
   assign emit     = (state_ff != S_IDLE) && can_emit;
   assign is_last  = (idx_ff == last_idx_ff);
   assign load     = !q_stat.empty && ((state_ff == S_IDLE) || (emit && is_last));
   assign q_read   = load;
   assign qe_bit   = 3'(4'd8 - idx_ff);

   // Sequence kind and length of the waiting descriptor.
   always_comb begin
      load_state = S_ERROR;
      load_last  = 4'd0;
      case (q_rd_data.kind)
         KIND_QUAD_EN: begin
            load_state = S_QUAD;
            load_last  = QUAD_EN_LAST;
         end
         KIND_RESET_SPI: begin
            load_state = S_RESET;
            load_last  = RESET_SPI_LAST;
         end
         KIND_START: begin
            load_state = S_START;
            load_last  = ADDR_LAST + q_rd_data.dummies;
         end
         KIND_WR_DATA: begin
            load_state = S_WDATA;
            load_last  = 4'd1;
         end
         KIND_RD_DATA: begin
            load_state = S_RDATA;
            load_last  = 4'd1;
         end
         KIND_END: begin
            load_state = S_END;
         end
         default: begin
            load_state = S_ERROR;
         end
      endcase
   end

   // Pin event for the current beat.
   always_comb begin
      ev_cs  = 1'b0;
      ev_clk = 1'b0;
      ev_val = 4'd0;
      ev_drv = 1'b0;
      ev_rb  = 8'd0;
      ev_bv  = 1'b0;
      ev_st  = STATUS_OK;
      case (state_ff)
         S_QUAD: begin
            ev_drv = 1'b1;
            if (idx_ff == 4'd0) begin
               ev_val = SERIAL_IDLE;
            end else if (idx_ff == QUAD_EN_LAST) begin
               ev_cs  = 1'b1;
               ev_val = SERIAL_IDLE;
            end else begin
               ev_clk = 1'b1;
               ev_val = {3'b000, QUAD_EN_CMD[qe_bit]};
            end
         end
         S_RESET: begin
            ev_drv = 1'b1;
            ev_val = QUAD_IDLE;
            if (idx_ff == RESET_SPI_LAST) begin
               ev_cs = 1'b1;
            end else if (idx_ff != 4'd0) begin
               ev_clk = 1'b1;
            end
         end
         S_START: begin
            if (idx_ff == 4'd0) begin
               ev_val = QUAD_IDLE;
               ev_drv = 1'b1;
            end else if (idx_ff == 4'd1) begin
               ev_clk = 1'b1;
               ev_drv = 1'b1;
            end else if (idx_ff == 4'd2) begin
               ev_clk = 1'b1;
               ev_val = cmd_ff;
               ev_drv = 1'b1;
            end else if (idx_ff <= ADDR_LAST) begin
               ev_clk = 1'b1;
               ev_val = addr_ff[ADDR_W-1 -: 4];
               ev_drv = 1'b1;
            end else begin
               ev_clk = 1'b1;
            end
         end
         S_WDATA: begin
            ev_clk = 1'b1;
            ev_drv = 1'b1;
            ev_val = (idx_ff == 4'd0) ? data_ff[7:4] : data_ff[3:0];
         end
         S_RDATA: begin
            ev_clk = 1'b1;
            if (idx_ff == 4'd1) begin
               ev_rb = rbyte_ff;
               ev_bv = 1'b1;
            end
         end
         S_END: begin
            ev_cs  = 1'b1;
            ev_val = QUAD_IDLE;
            ev_drv = 1'b1;
         end
         S_ERROR: begin
            ev_cs = cs_ff;
            ev_st = status_ff;
         end
         default: begin
            ev_cs = 1'b0;
         end
      endcase
   end

   // Sequencer state: beat counter, address shifter and next descriptor.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      addr_in      = addr_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + 1'b1;
         if (state_ff == S_START && idx_ff >= ADDR_FIRST && idx_ff <= ADDR_LAST) begin
            addr_in = addr_ff << 4;
         end
         if (is_last) begin
            state_in = S_IDLE;
         end
      end
      if (load) begin
         state_in    = load_state;
         idx_in      = 4'd0;
         last_idx_in = load_last;
         addr_in     = ADDR_W'(q_rd_data.address);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 4'd0;
         last_idx_ff  <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_idx_ff  <= last_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Descriptor payload and the result register carry no reset.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (load) begin
         cmd_ff    <= q_rd_data.cmd;
         data_ff   <= q_rd_data.data_byte;
         rbyte_ff  <= q_rd_data.read_byte;
         cs_ff     <= q_rd_data.cs_n;
         status_ff <= q_rd_data.status;
      end
      if (emit) begin
         out_cs_ff   <= ev_cs;
         out_clk_ff  <= ev_clk;
         out_val_ff  <= ev_val;
         out_drv_ff  <= ev_drv;
         out_rb_ff   <= ev_rb;
         out_bv_ff   <= ev_bv;
         out_st_ff   <= ev_st;
         out_last_ff <= is_last;
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_chip_select_n = out_cs_ff;
   assign rsp_clock_pulse   = out_clk_ff;
   assign rsp_sio_value     = out_val_ff;
   assign rsp_sio_drive     = out_drv_ff;
   assign rsp_read_byte     = out_rb_ff;
   assign rsp_byte_valid    = out_bv_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_last          = out_last_ff;

`ifndef ASSERT_OFF
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> idx_ff <= last_idx_ff)
      else $error("beat counter ran past the end of the sequence");
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_status != STATUS_OK |-> rsp_last && !rsp_clock_pulse)
      else $error("error event is not a single closing event");
   a_read_sample: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_byte_valid |-> rsp_clock_pulse && !rsp_sio_drive && rsp_last)
      else $error("read byte returned on a driven or non-final beat");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      q_read |-> state_ff == S_IDLE || (emit && is_last))
      else $error("descriptor taken while a sequence is still running");
`endif

endmodule

`default_nettype wire

// ===== rtl/quad_spi_sram_master.sv =====
// A request passes the descriptor queue and sequencer state; its pin events leave registered.
// Throughput: one pin event per cycle while pop frees the result register; 1 to 15 per item.
// The pin sequencer sets the pace; a short descriptor queue lets requests enter meanwhile.
// Reset (synchronous, active high): serial mode, no transfer open, dummy_beats 2, queue empty.
`default_nettype none

module quad_spi_sram_master #(
   parameter int ADDR_BITS   = qssm_pkg::DEF_ADDR_BITS,
   parameter int QUEUE_DEPTH = qssm_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [3:0]  req_pin_high_nibble,
   input  wire logic [3:0]  req_pin_low_nibble,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_chip_select_n,
   output logic             rsp_clock_pulse,
   output logic [3:0]       rsp_sio_value,
   output logic             rsp_sio_drive,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_byte_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [3:0]  csr_dummy_beats
);
   import qssm_pkg::*;

   queue_stat_type q_stat;
   desc_type       q_wr_data;
   desc_type       q_rd_data;
   logic           q_write;
   logic           q_read;

   assign full = q_stat.full;

   // Request checking and classification.
   qssm_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .req_op              (req_op),
      .req_address         (req_address),
      .req_data_byte       (req_data_byte),
      .req_pin_high_nibble (req_pin_high_nibble),
      .req_pin_low_nibble  (req_pin_low_nibble),
      .csr_write           (csr_write),
      .csr_dummy_beats     (csr_dummy_beats),
      .q_stat              (q_stat),
      .q_write             (q_write),
      .q_wr_data           (q_wr_data)
   );

   // Descriptors waiting for the sequencer.
   qssm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_write),
      .wr_data (q_wr_data),
      .rd_en   (q_read),
      .rd_data (q_rd_data),
      .stat    (q_stat)
   );

   // Pin event generation and result register.
   qssm_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .q_rd_data         (q_rd_data),
      .q_read            (q_read),
      .pop               (pop),
      .empty             (empty),
      .rsp_chip_select_n (rsp_chip_select_n),
      .rsp_clock_pulse   (rsp_clock_pulse),
      .rsp_sio_value     (rsp_sio_value),
      .rsp_sio_drive     (rsp_sio_drive),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the quad-SPI serial SRAM master: predicts every pin event.
module tb_top;
   import qssm_pkg::*;

   // Op codes that the block must reject as out of sequence.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_REQUESTS = 50;

   // One pin event as it leaves the block.
   typedef struct {
      logic       cs_n;
      logic       clk_pulse;
      logic [3:0] sio_value;
      logic       sio_drive;
      logic [7:0] read_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       last;
   } pin_event_type;

   // Predicts the pin events of each request and checks the block against them.
   class pin_event_scoreboard;
      localparam int ADDR_NIBBLES = (DEF_ADDR_BITS + 3) / 4;

      logic       quad_on;
      logic [1:0] open_kind;
      logic [3:0] dummy_setting;
      pin_event_type pending_events[$];
      int         failures;

      function new();
         quad_on = 1'b0;
         open_kind = OPEN_NONE;
         dummy_setting = DUMMY_RESET;
         failures = 0;
      endfunction

      function void set_dummy(logic [3:0] value);
         dummy_setting = value;
      endfunction

      function void add_beat(logic cs_n, logic clk_pulse, logic [3:0] value, logic drive,
                             logic [7:0] rd_byte, logic valid, logic [1:0] status);
         pin_event_type beat;
         beat.cs_n = cs_n;
         beat.clk_pulse = clk_pulse;
         beat.sio_value = value;
         beat.sio_drive = drive;
         beat.read_byte = rd_byte;
         beat.byte_valid = valid;
         beat.status = status;
         beat.last = 1'b0;
         pending_events.push_back(beat);
      endfunction

      // Select, command nibbles, address nibbles msb first, then hi-Z dummy beats.
      function void add_header(logic [3:0] cmd, logic [15:0] address, int dummies);
         logic [31:0] wide_addr;
         int i;
         wide_addr = {16'h0000, address};
         add_beat(1'b0, 1'b0, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
         add_beat(1'b0, 1'b1, 4'h0, 1'b1, 8'h00, 1'b0, STATUS_OK);
         add_beat(1'b0, 1'b1, cmd, 1'b1, 8'h00, 1'b0, STATUS_OK);
         for (i = ADDR_NIBBLES - 1; i >= 0; i--)
            add_beat(1'b0, 1'b1, wide_addr[4 * i +: 4], 1'b1, 8'h00, 1'b0, STATUS_OK);
         for (i = 0; i < dummies; i++)
            add_beat(1'b0, 1'b1, 4'h0, 1'b0, 8'h00, 1'b0, STATUS_OK);
      endfunction

      // Works out the pin events of one accepted request and updates the state.
      function void note_request(logic [2:0] op, logic [15:0] address, logic [7:0] data_byte,
                                 logic [3:0] pin_high, logic [3:0] pin_low);
         logic       rejected;
         logic [1:0] reject_code;
         int         dummies;
         int         i;
         rejected = 1'b0;
         reject_code = STATUS_SEQ;
         case (op)
            OP_QUAD_EN: begin
               if (open_kind != OPEN_NONE || quad_on) begin
                  rejected = 1'b1;
               end else begin
                  add_beat(1'b0, 1'b0, SERIAL_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  for (i = 7; i >= 0; i--)
                     add_beat(1'b0, 1'b1, {3'b000, QUAD_EN_CMD[i]}, 1'b1, 8'h00, 1'b0,
                              STATUS_OK);
                  add_beat(1'b1, 1'b0, SERIAL_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  quad_on = 1'b1;
               end
            end
            OP_RESET_SPI: begin
               if (open_kind != OPEN_NONE) begin
                  rejected = 1'b1;
               end else begin
                  add_beat(1'b0, 1'b0, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  add_beat(1'b0, 1'b1, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  add_beat(1'b0, 1'b1, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  add_beat(1'b1, 1'b0, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  quad_on = 1'b0;
               end
            end
            OP_WRITE_START, OP_READ_START: begin
               if (open_kind != OPEN_NONE) begin
                  rejected = 1'b1;
               end else if (!quad_on) begin
                  rejected = 1'b1;
                  reject_code = STATUS_MODE;
               end else if (op == OP_WRITE_START) begin
                  add_header(WRITE_CMD, address, 0);
                  open_kind = OPEN_WRITE;
               end else begin
                  // Dummy count saturates, and a read start never exceeds the event limit.
                  dummies = (dummy_setting > DUMMY_MAX) ? DUMMY_MAX : dummy_setting;
                  if (dummies > MAX_EVENTS - 3 - ADDR_NIBBLES)
                     dummies = MAX_EVENTS - 3 - ADDR_NIBBLES;
                  add_header(READ_CMD, address, dummies);
                  open_kind = OPEN_READ;
               end
            end
            OP_DATA: begin
               if (open_kind == OPEN_WRITE) begin
                  add_beat(1'b0, 1'b1, data_byte[7:4], 1'b1, 8'h00, 1'b0, STATUS_OK);
                  add_beat(1'b0, 1'b1, data_byte[3:0], 1'b1, 8'h00, 1'b0, STATUS_OK);
               end else if (open_kind == OPEN_READ) begin
                  add_beat(1'b0, 1'b1, 4'h0, 1'b0, 8'h00, 1'b0, STATUS_OK);
                  add_beat(1'b0, 1'b1, 4'h0, 1'b0, {pin_high, pin_low}, 1'b1, STATUS_OK);
               end else begin
                  rejected = 1'b1;
               end
            end
            OP_END: begin
               if (open_kind == OPEN_NONE) begin
                  rejected = 1'b1;
               end else begin
                  add_beat(1'b1, 1'b0, QUAD_IDLE, 1'b1, 8'h00, 1'b0, STATUS_OK);
                  open_kind = OPEN_NONE;
               end
            end
            default: rejected = 1'b1;
         endcase
         // A rejected request gives one event at the current select level.
         if (rejected)
            add_beat(open_kind == OPEN_NONE, 1'b0, 4'h0, 1'b0, 8'h00, 1'b0, reject_code);
         pending_events[pending_events.size() - 1].last = 1'b1;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         failures++;
      endtask

      task compare_field(string name, logic [7:0] got_value, logic [7:0] want_value);
         if (got_value !== want_value)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got_value, want_value));
      endtask

      // Compares one pin event with the oldest prediction.
      task check_event(pin_event_type got);
         pin_event_type want;
         if (pending_events.size() == 0) begin
            report_mismatch("pin event with no request pending");
            return;
         end
         want = pending_events.pop_front();
         compare_field("chip_select_n", got.cs_n, want.cs_n);
         compare_field("clock_pulse", got.clk_pulse, want.clk_pulse);
         compare_field("sio_value", got.sio_value, want.sio_value);
         compare_field("sio_drive", got.sio_drive, want.sio_drive);
         compare_field("read_byte", got.read_byte, want.read_byte);
         compare_field("byte_valid", got.byte_valid, want.byte_valid);
         compare_field("status", got.status, want.status);
         compare_field("last", got.last, want.last);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [2:0]  req_op;
   logic [15:0] req_address;
   logic [7:0]  req_data_byte;
   logic [3:0]  req_pin_high_nibble;
   logic [3:0]  req_pin_low_nibble;
   logic        empty;
   logic        pop;
   logic        rsp_chip_select_n;
   logic        rsp_clock_pulse;
   logic [3:0]  rsp_sio_value;
   logic        rsp_sio_drive;
   logic [7:0]  rsp_read_byte;
   logic        rsp_byte_valid;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_write;
   logic [3:0]  csr_dummy_beats;

   pin_event_scoreboard sb = new();
   bit no_gaps = 1'b0;
   int requests_sent = 0;
   int idle_cycles = 0;
   logic [3:0] dummy_plan [8] = '{4'd0, 4'd8, 4'd15, 4'd9, 4'd1, 4'd3, 4'd2, 4'd7};

   quad_spi_sram_master i_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_op              (req_op),
      .req_address         (req_address),
      .req_data_byte       (req_data_byte),
      .req_pin_high_nibble (req_pin_high_nibble),
      .req_pin_low_nibble  (req_pin_low_nibble),
      .empty               (empty),
      .pop                 (pop),
      .rsp_chip_select_n   (rsp_chip_select_n),
      .rsp_clock_pulse     (rsp_clock_pulse),
      .rsp_sio_value       (rsp_sio_value),
      .rsp_sio_drive       (rsp_sio_drive),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last),
      .csr_write           (csr_write),
      .csr_dummy_beats     (csr_dummy_beats)
   );

   always #5 clock = ~clock;

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side: random pop gaps, each pin event is checked on its transfer.
   initial begin
      pin_event_type got;
      int gap;
      pop = 1'b0;
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop = 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         got.cs_n = rsp_chip_select_n;
         got.clk_pulse = rsp_clock_pulse;
         got.sio_value = rsp_sio_value;
         got.sio_drive = rsp_sio_drive;
         got.read_byte = rsp_read_byte;
         got.byte_valid = rsp_byte_valid;
         got.status = rsp_status;
         got.last = rsp_last;
         sb.check_event(got);
         @(negedge clock);
      end
   end

   // Drives one request after a random gap and notes it once its transfer happens.
   task automatic send_request(logic [2:0] op, logic [15:0] address, logic [7:0] data_byte,
                               logic [3:0] pin_high, logic [3:0] pin_low);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push = 1'b1;
      req_op = op;
      req_address = address;
      req_data_byte = data_byte;
      req_pin_high_nibble = pin_high;
      req_pin_low_nibble = pin_low;
      do @(posedge clock); while (full !== 1'b0);
      sb.note_request(op, address, data_byte, pin_high, pin_low);
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(logic [2:0] op);
      send_request(op, pick_address(), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   // Holds the sender back until every predicted pin event has come out.
   task automatic drain_results();
      push = 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_dummy(logic [3:0] value);
      drain_results();
      csr_write = 1'b1;
      csr_dummy_beats = value;
      @(negedge clock);
      csr_write = 1'b0;
      sb.set_dummy(value);
   endtask

   // A well-formed transaction with random content, now and then broken.
   task automatic run_transaction();
      int n_data;
      int i;
      if (!sb.quad_on) begin
         send_random(OP_QUAD_EN);
      end else if ($urandom_range(0, 19) == 0) begin
         send_random(OP_RESET_SPI);
         send_random(OP_QUAD_EN);
      end
      send_random($urandom_range(0, 1) ? OP_WRITE_START : OP_READ_START);
      n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      for (i = 0; i < n_data; i++) begin
         if ($urandom_range(0, 14) == 0)
            send_random(3'($urandom_range(0, 7)));
         else
            send_random(OP_DATA);
      end
      if ($urandom_range(0, 19) != 0)
         send_random(OP_END);
   endtask

   task automatic run_phase(int count);
      int target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(0, 29) == 0)
            drain_results();
         if ($urandom_range(0, 9) == 0)
            send_random(3'($urandom_range(0, 7)));
         else
            run_transaction();
      end
   endtask

   initial begin
      int p;
      reset = 1'b1;
      push = 1'b0;
      req_op = OP_QUAD_EN;
      req_address = 16'h0000;
      req_data_byte = 8'h00;
      req_pin_high_nibble = 4'h0;
      req_pin_low_nibble = 4'h0;
      csr_write = 1'b0;
      csr_dummy_beats = 4'h0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: sequence and mode errors, spare ops, field extremes.
      send_request(OP_DATA, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_END, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_WRITE_START, 16'h1234, 8'h00, 4'h0, 4'h0);
      send_request(OP_READ_START, 16'hFFFF, 8'h00, 4'h0, 4'h0);
      send_request(OP_SPARE_6, 16'hFFFF, 8'hFF, 4'hF, 4'hF);
      send_request(OP_SPARE_7, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_RESET_SPI, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_QUAD_EN, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_QUAD_EN, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_WRITE_START, 16'hFFFF, 8'h00, 4'h0, 4'h0);
      send_request(OP_DATA, 16'h0000, 8'hFF, 4'h0, 4'h0);
      send_request(OP_DATA, 16'hFFFF, 8'h00, 4'hF, 4'hF);
      send_request(OP_WRITE_START, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_READ_START, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_QUAD_EN, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_RESET_SPI, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_SPARE_7, 16'hFFFF, 8'hFF, 4'hF, 4'hF);
      send_request(OP_END, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_READ_START, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_DATA, 16'h0000, 8'hAA, 4'hF, 4'h0);
      send_request(OP_DATA, 16'h0000, 8'h55, 4'h0, 4'hF);
      send_request(OP_END, 16'h0000, 8'h00, 4'h0, 4'h0);
      send_request(OP_RESET_SPI, 16'h0000, 8'h00, 4'h0, 4'h0);

      // Random phases, each under its own dummy setting and idling mode.
      for (p = 0; p < 8; p++) begin
         write_dummy(dummy_plan[p]);
         no_gaps = ($urandom_range(0, 3) == 0);
         run_phase(PHASE_REQUESTS);
      end

      push = 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/qssm_pkg.sv
rtl/qssm_front.sv
rtl/qssm_queue.sv
rtl/qssm_back.sv
rtl/quad_spi_sram_master.sv
tb/tb_top.sv
